/* rtl/core/tbps_pkg.sv */
// Shared types, constants and register codes for the tilt ball physics step.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package tbps_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int COORD_BITS_DEF = 10;

    localparam int DIM_W      = 10;
    localparam int RAD_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 16;
    localparam int DZ_W       = 15;
    localparam int TILT_W     = 17;
    localparam int VEL_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W = ((2 * TILT_W + 7) / 8) * 8;
    localparam int OP_W       = 4;

    localparam int TILT_DEG = 90;
    localparam int STOP_NUM = 13;

    localparam logic signed [GAIN_W:0] BOUNCE_Q16 = -17'sd26214;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BALL_RADIUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE     = 3'd7;

    localparam logic [OP_W-1:0] OP_IDLE       = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL_TILT   = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_CENT   = 4'd3;
    localparam logic [OP_W-1:0] OP_SAT        = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_DAMP   = 4'd5;
    localparam logic [OP_W-1:0] OP_CLAMP_HI   = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL_BOUNCE = 4'd7;
    localparam logic [OP_W-1:0] OP_CLAMP_LO   = 4'd8;
    localparam logic [OP_W-1:0] OP_COMMIT     = 4'd9;
    localparam logic [OP_W-1:0] OP_PIXEL      = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            axis;
        logic            recentre;
    } cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0]  screen_width;
        logic [DIM_W-1:0]  screen_height;
        logic [RAD_W-1:0]  ball_radius;
        logic [GAIN_W-1:0] tilt_gain;
        logic [GAIN_W-1:0] center_gain;
        logic [GAIN_W-1:0] damping_gain;
        logic [LIM_W-1:0]  speed_limit;
        logic [DZ_W-1:0]   dead_zone;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        screen_width:  10'd320,
        screen_height: 10'd240,
        ball_radius:   8'd25,
        tilt_gain:     16'd19661,
        center_gain:   16'd1311,
        damping_gain:  16'd64881,
        speed_limit:   16'd25600,
        dead_zone:     15'd256
    };

endpackage

/* rtl/core/tbps_ctrl.sv */
// Sequencer of the tilt ball physics step: walks both axes through the
// shared multiplier and issues one command per cycle. Depends on tbps_pkg.
`timescale 1ns / 1ps

module tbps_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_action,
    input  logic          out_free,
    output logic          in_ready,
    output tbps_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_TILT   = 4'd1;
    localparam logic [3:0] ST_CENT   = 4'd2;
    localparam logic [3:0] ST_SAT    = 4'd3;
    localparam logic [3:0] ST_DAMP   = 4'd4;
    localparam logic [3:0] ST_CHI    = 4'd5;
    localparam logic [3:0] ST_BNC1   = 4'd6;
    localparam logic [3:0] ST_CLO    = 4'd7;
    localparam logic [3:0] ST_BNC2   = 4'd8;
    localparam logic [3:0] ST_COMMIT = 4'd9;
    localparam logic [3:0] ST_PIX    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        cmd.op       = tbps_pkg::OP_IDLE;
        cmd.axis     = axis_reg;
        cmd.recentre = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op       = tbps_pkg::OP_LOAD;
                    cmd.recentre = in_action;
                    axis_next    = 1'b0;
                    state_next   = ST_TILT;
                end
            end
            ST_TILT:
            begin
                cmd.op     = tbps_pkg::OP_MUL_TILT;
                state_next = ST_CENT;
            end
            ST_CENT:
            begin
                cmd.op     = tbps_pkg::OP_MUL_CENT;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.op     = tbps_pkg::OP_SAT;
                state_next = ST_DAMP;
            end
            ST_DAMP:
            begin
                cmd.op     = tbps_pkg::OP_MUL_DAMP;
                state_next = ST_CHI;
            end
            ST_CHI:
            begin
                cmd.op     = tbps_pkg::OP_CLAMP_HI;
                state_next = ST_BNC1;
            end
            ST_BNC1:
            begin
                cmd.op     = tbps_pkg::OP_MUL_BOUNCE;
                state_next = ST_CLO;
            end
            ST_CLO:
            begin
                cmd.op     = tbps_pkg::OP_CLAMP_LO;
                state_next = ST_BNC2;
            end
            ST_BNC2:
            begin
                cmd.op     = tbps_pkg::OP_MUL_BOUNCE;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.op = tbps_pkg::OP_COMMIT;
                if (axis_reg)
                begin
                    state_next = ST_PIX;
                end
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_TILT;
                end
            end
            ST_PIX:
            begin
                if (out_free)
                begin
                    cmd.op     = tbps_pkg::OP_PIXEL;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/tbps_datapath.sv */
// Datapath of the tilt ball physics step: ball state, one shared multiplier,
// clamps and the pixel centre logic. Depends on tbps_pkg.
`timescale 1ns / 1ps

module tbps_datapath
#(
    parameter int FRAC_BITS  = tbps_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = tbps_pkg::COORD_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tbps_pkg::cmd_t                        cmd,
    input  tbps_pkg::cfg_t                        cfg,
    input  logic signed [tbps_pkg::TILT_W-1:0]    pitch_angle,
    input  logic signed [tbps_pkg::TILT_W-1:0]    roll_angle,
    output logic [COORD_BITS-1:0]                 ball_x,
    output logic [COORD_BITS-1:0]                 ball_y,
    output logic [COORD_BITS-1:0]                 old_x,
    output logic [COORD_BITS-1:0]                 old_y,
    output logic                                  redraw,
    output logic                                  erase_old
);

    localparam int TILT_W  = tbps_pkg::TILT_W;
    localparam int VEL_W   = tbps_pkg::VEL_W;
    localparam int DIM_W   = tbps_pkg::DIM_W;
    localparam int GAIN_W  = tbps_pkg::GAIN_W;
    localparam int POS_W   = DIM_W + FRAC_BITS;
    localparam int MA_W    = (POS_W > TILT_W) ? POS_W : TILT_W;
    localparam int MB_W    = GAIN_W + 1;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int SUM_W   = MA_W + 2;
    localparam int PX_W    = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;
    localparam int TCMP_W  = ((FRAC_BITS + 8 > TILT_W) ? FRAC_BITS + 8 : TILT_W) + 1;
    localparam int STOP_EPS = ((tbps_pkg::STOP_NUM << FRAC_BITS) + 128) / 256;

    localparam logic signed [TCMP_W-1:0] TILT_LIM =
        TCMP_W'(tbps_pkg::TILT_DEG) <<< FRAC_BITS;
    localparam logic [VEL_W:0] STOP_EPS_V = (VEL_W + 1)'(STOP_EPS);

    logic signed [TILT_W-1:0]  tilt_reg [2];
    logic signed [POS_W-1:0]   pos_reg [2];
    logic signed [VEL_W-1:0]   vel_reg [2];
    logic [COORD_BITS-1:0]     origin_reg [2];
    logic [COORD_BITS-1:0]     drawn_reg [2];
    logic                      first_reg;

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [TILT_W-1:0]  acc_reg;
    logic signed [VEL_W-1:0]   v_reg;
    logic signed [SUM_W-1:0]   p_reg;
    logic                      flag_reg;

    function automatic logic signed [TILT_W-1:0] shape_tilt(
        input logic signed [TILT_W-1:0] t,
        input logic [tbps_pkg::DZ_W-1:0] dz
    );
        logic signed [TCMP_W-1:0] tw;
        logic [TCMP_W-1:0]        mag;
        logic [TCMP_W-1:0]        dz_w;
        logic signed [TCMP_W-1:0] res;
        begin
            tw   = TCMP_W'(t);
            mag  = (tw < 0) ? -tw : tw;
            dz_w = TCMP_W'(dz);
            if (mag < dz_w)
                res = '0;
            else if (tw > TILT_LIM)
                res = TILT_LIM;
            else if (tw < -TILT_LIM)
                res = -TILT_LIM;
            else
                res = tw;
            return TILT_W'(res);
        end
    endfunction

    function automatic logic [COORD_BITS-1:0] pixel_of(
        input logic [COORD_BITS-1:0]       origin,
        input logic signed [POS_W-1:0]     pos,
        input logic [DIM_W-1:0]            dim,
        input logic [tbps_pkg::RAD_W-1:0]  radius
    );
        logic signed [POS_W:0]   pw;
        logic signed [POS_W:0]   mag;
        logic signed [PX_W-1:0]  whole;
        logic signed [PX_W-1:0]  c;
        logic signed [PX_W-1:0]  r_s;
        logic signed [PX_W-1:0]  hi;
        begin
            pw    = (POS_W + 1)'(pos);
            mag   = (pw < 0) ? -pw : pw;
            whole = PX_W'(mag >>> FRAC_BITS);
            if (pw < 0)
                whole = -whole;
            c   = PX_W'(origin) + whole;
            r_s = PX_W'(radius);
            hi  = PX_W'(dim) - r_s;
            if (c < r_s)
                c = r_s;
            if (c > hi)
                c = hi;
            return c[COORD_BITS-1:0];
        end
    endfunction

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [VEL_W-1:0]   prod_v;
    logic [DIM_W-1:0]          dim_sel;
    logic signed [DIM_W:0]     bnd_pix;
    logic signed [SUM_W-1:0]   bound;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   lim_s;
    logic signed [VEL_W-1:0]   v_sat;
    logic signed [VEL_W-1:0]   v_damp;
    logic [VEL_W:0]            v_abs;
    logic signed [SUM_W-1:0]   p_hi;
    logic                      hit_hi;
    logic signed [VEL_W-1:0]   v_lo;
    logic signed [SUM_W-1:0]   p_lo;
    logic                      hit_lo;
    logic signed [VEL_W-1:0]   v_fin;
    logic [COORD_BITS-1:0]     nx, ny;
    logic                      redraw_c;

    always_comb
    begin
        case (cmd.op)
            tbps_pkg::OP_MUL_TILT:
            begin
                mul_a = MA_W'(tilt_reg[cmd.axis]);
                mul_b = $signed({1'b0, cfg.tilt_gain});
            end
            tbps_pkg::OP_MUL_CENT:
            begin
                mul_a = MA_W'(pos_reg[cmd.axis]);
                mul_b = $signed({1'b0, cfg.center_gain});
            end
            tbps_pkg::OP_MUL_DAMP:
            begin
                mul_a = MA_W'(v_reg);
                mul_b = $signed({1'b0, cfg.damping_gain});
            end
            tbps_pkg::OP_MUL_BOUNCE:
            begin
                mul_a = MA_W'(v_reg);
                mul_b = tbps_pkg::BOUNCE_Q16;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        prod_sh = prod_reg >>> GAIN_W;
        prod_v  = VEL_W'(prod_sh);

        dim_sel = cmd.axis ? cfg.screen_height : cfg.screen_width;
        bnd_pix = $signed({2'b00, dim_sel[DIM_W-1:1]}) -
                  $signed((DIM_W + 1)'(cfg.ball_radius));
        bound   = SUM_W'(bnd_pix) <<< FRAC_BITS;

        sum   = SUM_W'(vel_reg[cmd.axis]) + SUM_W'(acc_reg) - SUM_W'(prod_sh);
        lim_s = $signed(SUM_W'(cfg.speed_limit));
        if (sum > lim_s)
            v_sat = VEL_W'(lim_s);
        else if (sum < -lim_s)
            v_sat = VEL_W'(-lim_s);
        else
            v_sat = VEL_W'(sum);

        v_damp = prod_v;
        v_abs  = (v_damp < 0) ? -((VEL_W + 1)'(v_damp)) : (VEL_W + 1)'(v_damp);
        if (v_abs < STOP_EPS_V)
            v_damp = '0;
        p_hi   = SUM_W'(pos_reg[cmd.axis]) + SUM_W'(v_damp);
        hit_hi = (p_hi > bound);
        if (hit_hi)
            p_hi = bound;

        v_lo   = flag_reg ? prod_v : v_reg;
        hit_lo = (p_reg < -bound);
        p_lo   = hit_lo ? -bound : p_reg;

        v_fin = flag_reg ? prod_v : v_reg;

        nx = pixel_of(origin_reg[0], pos_reg[0], cfg.screen_width, cfg.ball_radius);
        ny = pixel_of(origin_reg[1], pos_reg[1], cfg.screen_height, cfg.ball_radius);
        redraw_c = first_reg || (nx != drawn_reg[0]) || (ny != drawn_reg[1]);
    end

    assign ball_x    = nx;
    assign ball_y    = ny;
    assign old_x     = drawn_reg[0];
    assign old_y     = drawn_reg[1];
    assign redraw    = redraw_c;
    assign erase_old = redraw_c && !first_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tbps_pkg::OP_LOAD:
            begin
                tilt_reg[0] <= shape_tilt(pitch_angle, cfg.dead_zone);
                tilt_reg[1] <= shape_tilt(roll_angle, cfg.dead_zone);
            end
            tbps_pkg::OP_MUL_TILT,
            tbps_pkg::OP_MUL_DAMP,
            tbps_pkg::OP_MUL_BOUNCE:
            begin
                prod_reg <= mul_a * mul_b;
            end
            tbps_pkg::OP_MUL_CENT:
            begin
                acc_reg  <= TILT_W'(prod_sh);
                prod_reg <= mul_a * mul_b;
            end
            tbps_pkg::OP_SAT:
            begin
                v_reg <= v_sat;
            end
            tbps_pkg::OP_CLAMP_HI:
            begin
                v_reg    <= v_damp;
                p_reg    <= p_hi;
                flag_reg <= hit_hi;
            end
            tbps_pkg::OP_CLAMP_LO:
            begin
                v_reg    <= v_lo;
                p_reg    <= p_lo;
                flag_reg <= hit_lo;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0]    <= '0;
            pos_reg[1]    <= '0;
            vel_reg[0]    <= '0;
            vel_reg[1]    <= '0;
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            drawn_reg[0]  <= '0;
            drawn_reg[1]  <= '0;
            first_reg     <= 1'b1;
        end
        else
        begin
            case (cmd.op)
                tbps_pkg::OP_LOAD:
                begin
                    if (cmd.recentre)
                    begin
                        origin_reg[0] <= COORD_BITS'(cfg.screen_width[DIM_W-1:1]);
                        origin_reg[1] <= COORD_BITS'(cfg.screen_height[DIM_W-1:1]);
                        drawn_reg[0]  <= COORD_BITS'(cfg.screen_width[DIM_W-1:1]);
                        drawn_reg[1]  <= COORD_BITS'(cfg.screen_height[DIM_W-1:1]);
                        first_reg     <= 1'b1;
                        pos_reg[0]    <= '0;
                        pos_reg[1]    <= '0;
                        vel_reg[0]    <= '0;
                        vel_reg[1]    <= '0;
                    end
                end
                tbps_pkg::OP_COMMIT:
                begin
                    pos_reg[cmd.axis] <= POS_W'(p_reg);
                    vel_reg[cmd.axis] <= v_fin;
                end
                tbps_pkg::OP_PIXEL:
                begin
                    if (redraw_c)
                    begin
                        drawn_reg[0] <= nx;
                        drawn_reg[1] <= ny;
                        first_reg    <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* rtl/core/tilt_ball_physics_step.sv */
// Top level of the tilt ball physics step: configuration registers, output
// register and the controller and datapath. Depends on tbps_pkg, tbps_ctrl
// and tbps_datapath.
`timescale 1ns / 1ps

// Each accepted tilt sample moves the ball one step and yields one result.
// A sample is taken, then each axis in turn passes through the single shared
// multiplier (tilt, centering, damping and two bounce products, with the sums
// and clamps in between), and the pixel centre is formed and enters the output
// register once that register is free; no new sample is taken until then. A new
// sample is taken while an earlier result still waits on the output side. Register
// writes on the configuration channel are always taken and must arrive only while
// no sample is in progress.
module tilt_ball_physics_step
#(
    parameter int FRAC_BITS  = tbps_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = tbps_pkg::COORD_BITS_DEF,
    parameter int OUT_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0 up: pitch_angle, roll_angle, zero fill.
    input  logic [tbps_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Fields from bit 0 up: action.
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0 up: ball_x, ball_y, old_x, old_y, zero fill.
    output logic [OUT_TDATA_W-1:0]              m_tdata,
    // Fields from bit 0 up: redraw, erase_old.
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TILT_W = tbps_pkg::TILT_W;

    tbps_pkg::cfg_t cfg_reg;
    tbps_pkg::cmd_t cmd;

    logic                     out_valid_reg;
    logic [4*COORD_BITS-1:0]  out_data_reg;
    logic [1:0]               out_user_reg;
    logic                     out_free;
    logic [COORD_BITS-1:0]    ball_x, ball_y, old_x, old_y;
    logic                     redraw, erase_old;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tbps_pkg::CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tbps_pkg::REG_SCREEN_WIDTH:
                    cfg_reg.screen_width <= cfg_data[tbps_pkg::DIM_W-1:0];
                tbps_pkg::REG_SCREEN_HEIGHT:
                    cfg_reg.screen_height <= cfg_data[tbps_pkg::DIM_W-1:0];
                tbps_pkg::REG_BALL_RADIUS:
                    cfg_reg.ball_radius <= cfg_data[tbps_pkg::RAD_W-1:0];
                tbps_pkg::REG_TILT_GAIN:
                    cfg_reg.tilt_gain <= cfg_data[tbps_pkg::GAIN_W-1:0];
                tbps_pkg::REG_CENTER_GAIN:
                    cfg_reg.center_gain <= cfg_data[tbps_pkg::GAIN_W-1:0];
                tbps_pkg::REG_DAMPING_GAIN:
                    cfg_reg.damping_gain <= cfg_data[tbps_pkg::GAIN_W-1:0];
                tbps_pkg::REG_SPEED_LIMIT:
                    cfg_reg.speed_limit <= cfg_data[tbps_pkg::LIM_W-1:0];
                tbps_pkg::REG_DEAD_ZONE:
                    cfg_reg.dead_zone <= cfg_data[tbps_pkg::DZ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    tbps_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .out_free  (out_free),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    tbps_datapath
    #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg_reg),
        .pitch_angle ($signed(s_tdata[TILT_W-1:0])),
        .roll_angle  ($signed(s_tdata[2*TILT_W-1:TILT_W])),
        .ball_x      (ball_x),
        .ball_y      (ball_y),
        .old_x       (old_x),
        .old_y       (old_y),
        .redraw      (redraw),
        .erase_old   (erase_old)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == tbps_pkg::OP_PIXEL)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == tbps_pkg::OP_PIXEL)
        begin
            out_data_reg <= {old_y, old_x, ball_y, ball_x};
            out_user_reg <= {erase_old, redraw};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);
    assign m_tuser  = out_user_reg;

endmodule

/* rtl/core/tbps_checker.sv */
// Port-level checks for the tilt ball physics step, attached by bind.
// Depends on tbps_pkg and the top level's ports.
`timescale 1ns / 1ps

module tbps_checker
#(
    parameter int COORD_BITS  = tbps_pkg::COORD_BITS_DEF,
    parameter int OUT_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [1:0]             m_tuser
);

    localparam int C = COORD_BITS;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result changed or was dropped.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input taken while a sample is in progress.");

    a_erase_needs_redraw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[1] && !m_tuser[0]))
        else $error("Erase flagged without redraw.");

    a_still_means_same: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |->
            (m_tdata[C-1:0] == m_tdata[3*C-1:2*C]) &&
            (m_tdata[2*C-1:C] == m_tdata[4*C-1:3*C]))
        else $error("No redraw although the centre moved.");

endmodule

bind tilt_ball_physics_step tbps_checker
#(
    .COORD_BITS  (COORD_BITS),
    .OUT_TDATA_W (OUT_TDATA_W)
)
u_tbps_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
